### src/cnh_pkg.sv
// ----------------------------------------------------------------------------
// cnh_pkg: shared types and constants for the cellular noise pipeline
// Widths, hash constants, register map and the cell context record.
// ----------------------------------------------------------------------------
package cnh_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int FREQ_FRAC      = 16;
    localparam int NEIGHBOR_REACH = 2;
    localparam int SPAN           = 2 * NEIGHBOR_REACH + 1;
    localparam int NCELL          = SPAN * SPAN * SPAN;

    // base cell, offset cell, hash coordinate, feature point widths
    localparam int CELL_W = 32 - FRAC_BITS + 2;
    localparam int HC_W   = CELL_W + 1;
    localparam int FP_W   = CELL_W + FRAC_BITS + 1;
    localparam int OFF_W  = 3;
    localparam int J_W    = FRAC_BITS + 2;
    localparam int E_W    = FRAC_BITS + 4;
    localparam int D_W    = 2 * FRAC_BITS + 6;
    localparam int V_W    = D_W + 2;
    localparam int R_W    = V_W / 2;

    localparam int HASH_LAT = 4;
    localparam int CELL_LAT = HASH_LAT + 3;

    localparam logic [31:0] HK_X    = 32'd1619;
    localparam logic [31:0] HK_Y    = 32'd31337;
    localparam logic [31:0] HK_Z    = 32'd6971;
    localparam logic [31:0] HK_S    = 32'd1013;
    localparam logic [31:0] HK_MUL  = 32'd60493;
    localparam logic [31:0] HK_ADD1 = 32'd19990303;
    localparam logic [31:0] HK_ADD2 = 32'd1376312589;
    localparam int          HK_SHR  = 13;

    // register indexes
    localparam logic [1:0] REG_FREQ     = 2'd0;
    localparam logic [1:0] REG_CSEED    = 2'd1;
    localparam logic [1:0] REG_DIST_EN  = 2'd2;
    localparam logic [1:0] REG_RSEED    = 2'd3;

    typedef struct packed {
        logic [2:0][31:0]       p;
        logic [2:0][CELL_W-1:0] base;
        logic [2:0][FP_W-1:0]   best;
        logic [D_W-1:0]         bestd;
    } t_ctx;

endpackage

### src/cnh_hash.sv
// ----------------------------------------------------------------------------
// cnh_hash: pipelined integer cell hash to jitter
// Four register stages, one multiply in each after the first; output is 1 - H/2^30.
// ----------------------------------------------------------------------------
module cnh_hash import cnh_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [HC_W-1:0] i_x,
    input  logic [HC_W-1:0] i_y,
    input  logic [HC_W-1:0] i_z,
    input  logic [31:0]     i_k,
    output logic [J_W-1:0]  o_jit
);

    logic [31:0] w_a;
    logic [31:0] w_n;
    logic [31:0] w_h;
    logic [31:0] r_n0, r_n1, r_n2;
    logic [31:0] r_sq, r_t;
    logic [J_W-1:0] r_jit;

    always_comb begin
        w_a = HK_X * 32'($signed(i_x)) + HK_Y * 32'($signed(i_y))
            + HK_Z * 32'($signed(i_z)) + i_k;
        w_a[31] = 1'b0;
        w_n = w_a ^ (w_a >> HK_SHR);
        w_h = r_n2 * r_t + HK_ADD2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n0  <= w_n;
            r_sq  <= r_n0 * r_n0;
            r_n1  <= r_n0;
            r_t   <= r_sq * HK_MUL + HK_ADD1;
            r_n2  <= r_n1;
            r_jit <= J_W'(1 << FRAC_BITS) - J_W'({1'b0, w_h[30:30-FRAC_BITS]});
        end
    end

    assign o_jit = r_jit;

endmodule

### src/cnh_cell.sv
// ----------------------------------------------------------------------------
// cnh_cell: one neighbor cell of the search chain
// Hashes its cell, builds the feature point, squares the distance and keeps
// the nearest point in the context handed to the next cell.
// ----------------------------------------------------------------------------
module cnh_cell import cnh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_first,
    input  logic [OFF_W-1:0] i_dx,
    input  logic [OFF_W-1:0] i_dy,
    input  logic [OFF_W-1:0] i_dz,
    input  logic [31:0]      i_k0,
    input  logic [31:0]      i_k1,
    input  logic [31:0]      i_k2,
    input  t_ctx             i_ctx,
    output t_ctx             o_ctx
);

    logic [OFF_W-1:0]  w_off [3];
    logic [CELL_W-1:0] w_c   [3];
    logic [31:0]       w_k   [3];
    logic [J_W-1:0]    w_jit [3];
    logic [FP_W-1:0]   w_fp  [3];
    logic [D_W-1:0]    w_d2;

    t_ctx              r_ctx [6];
    logic [CELL_W-1:0] r_c   [4][3];
    logic [FP_W-1:0]   r_fp4 [3];
    logic [FP_W-1:0]   r_fp5 [3];
    logic [E_W-1:0]    r_e   [3];
    logic [2*E_W-1:0]  r_sq  [3];
    t_ctx              r_out;
    t_ctx              n_out;

    assign w_off[0] = i_dx;
    assign w_off[1] = i_dy;
    assign w_off[2] = i_dz;
    assign w_k[0]   = i_k0;
    assign w_k[1]   = i_k1;
    assign w_k[2]   = i_k2;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_c[a] = $signed(i_ctx.base[a]) + CELL_W'($signed(w_off[a]));
        assign w_fp[a] = (FP_W'($signed(r_c[3][a])) <<< FRAC_BITS)
                       + FP_W'($signed(w_jit[a]));

        cnh_hash u_hash (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (HC_W'($signed(w_c[0]))),
            .i_y   (HC_W'($signed(w_c[1]))),
            .i_z   (HC_W'($signed(w_c[2]))),
            .i_k   (w_k[a]),
            .o_jit (w_jit[a])
        );
    end

    assign w_d2 = D_W'(r_sq[0]) + D_W'(r_sq[1]) + D_W'(r_sq[2]);

    // strict compare: the first point found keeps ties
    always_comb begin
        n_out = r_ctx[5];
        if (i_first || (w_d2 < r_ctx[5].bestd)) begin
            n_out.bestd = w_d2;
            for (int a = 0; a < 3; a++) n_out.best[a] = r_fp5[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx[0] <= i_ctx;
            for (int s = 1; s < 6; s++) r_ctx[s] <= r_ctx[s-1];
            for (int a = 0; a < 3; a++) begin
                r_c[0][a] <= w_c[a];
                for (int s = 1; s < 4; s++) r_c[s][a] <= r_c[s-1][a];
                r_fp4[a] <= w_fp[a];
                r_e[a]   <= E_W'($signed(w_fp[a]) - FP_W'($signed(r_ctx[3].p[a])));
                r_fp5[a] <= r_fp4[a];
                r_sq[a]  <= (2*E_W)'($signed(r_e[a]) * $signed(r_e[a]));
            end
            r_out <= n_out;
        end
    end

    assign o_ctx = r_out;

endmodule

### src/cnh_sqrt.sv
// ----------------------------------------------------------------------------
// cnh_sqrt: pipelined integer square root
// One result bit per stage, digit by digit, truncating.
// ----------------------------------------------------------------------------
module cnh_sqrt import cnh_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [V_W-1:0] i_v,
    output logic [R_W-1:0] o_root
);

    localparam int RR_W = R_W + 2;

    logic [V_W-1:0]  r_v [R_W];
    logic [RR_W-1:0] r_r [R_W];
    logic [R_W-1:0]  r_q [R_W];

    for (genvar s = 0; s < R_W; s++) begin : g_stage
        logic [V_W-1:0]  w_vin;
        logic [RR_W-1:0] w_rin;
        logic [R_W-1:0]  w_qin;
        logic [RR_W-1:0] w_rr;
        logic [RR_W-1:0] w_t;

        if (s == 0) begin : g_head
            assign w_vin = i_v;
            assign w_rin = '0;
            assign w_qin = '0;
        end else begin : g_body
            assign w_vin = r_v[s-1];
            assign w_rin = r_r[s-1];
            assign w_qin = r_q[s-1];
        end

        assign w_rr = {w_rin[RR_W-3:0], w_vin[V_W-1 -: 2]};
        assign w_t  = {w_qin, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[s] <= {w_vin[V_W-3:0], 2'b00};
                if (w_rr >= w_t) begin
                    r_r[s] <= w_rr - w_t;
                    r_q[s] <= {w_qin[R_W-2:0], 1'b1};
                end else begin
                    r_r[s] <= w_rr;
                    r_q[s] <= {w_qin[R_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_q[R_W-1];

endmodule

### src/cellular_noise_3d.sv
// ----------------------------------------------------------------------------
// cellular_noise_3d: 3D cellular (Worley) noise, Q16.16 in and out
// Input channel i_valid/o_ready carries pos_x/y/z; output channel
// o_valid/i_ready carries noise_value. One transaction in gives one out.
// Path from input to o_valid: scale, 125 search cells of 7 stages, setup,
// 20-stage square root, output register. Throughput: one transaction per
// cycle while the receiver does not stall; each of the 125 cells in the chain
// evaluates one neighbor of every position.
// When the receiver stalls with the output register full, the whole chain
// holds and o_ready drops in the same cycle.
// Reset (synchronous, active low) empties the pipeline and loads
// frequency 1.0, both seeds 0, distance term off.
// Config: APB, registers at 0x0 frequency, 0x4 cell_seed,
// 0x8 distance_enable, 0xC result_seed; write only while idle.
// ----------------------------------------------------------------------------
module cellular_noise_3d import cnh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_noise_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PIPE_D = 2 + NCELL * CELL_LAT + 1 + R_W;
    localparam int JD_N   = R_W - HASH_LAT;
    localparam int PR_W   = 32 + 25;
    localparam int SH_W   = PR_W - FREQ_FRAC;
    localparam int RES_W  = 34;

    // ---------------- configuration registers ----------------
    logic [23:0] r_freq;
    logic [31:0] r_cseed;
    logic        r_dist_en;
    logic [31:0] r_rseed;
    logic [1:0]  w_idx;

    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq    <= 24'd65536;
            r_cseed   <= '0;
            r_dist_en <= 1'b0;
            r_rseed   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_FREQ:    r_freq    <= pwdata[23:0];
                REG_CSEED:   r_cseed   <= pwdata;
                REG_DIST_EN: r_dist_en <= pwdata[0];
                REG_RSEED:   r_rseed   <= pwdata;
                default:     r_freq    <= r_freq;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FREQ:    prdata = {8'd0, r_freq};
            REG_CSEED:   prdata = r_cseed;
            REG_DIST_EN: prdata = {31'd0, r_dist_en};
            REG_RSEED:   prdata = r_rseed;
            default:     prdata = '0;
        endcase
    end

    // seed terms of the hash, one per jitter axis and one for the result hash
    logic [31:0] w_k0, w_k1, w_k2, w_kr;
    assign w_k0 = HK_S * r_cseed;
    assign w_k1 = w_k0 + HK_S;
    assign w_k2 = w_k0 + (HK_S << 1);
    assign w_kr = HK_S * r_rseed;

    // ---------------- flow control ----------------
    // Whole pipeline moves together; output register acts as the skid.
    logic              w_en;
    logic [PIPE_D-1:0] r_vld;
    logic              r_out_vld;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[PIPE_D-2:0], i_valid};
            r_out_vld <= r_vld[PIPE_D-1];
        end
    end

    // ---------------- front: scale, saturate, base cell ----------------
    logic [31:0]     w_pos  [3];
    logic [PR_W-1:0] r_prod [3];
    logic [SH_W-1:0] w_sh   [3];
    logic [31:0]     w_p    [3];
    logic [CELL_W-1:0] w_base [3];
    t_ctx            r_ctx0;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sh[a] = SH_W'($signed(r_prod[a]) >>> FREQ_FRAC);
            if ($signed(w_sh[a]) > $signed(SH_W'(32'h7fff_ffff)))
                w_p[a] = 32'h7fff_ffff;
            else if ($signed(w_sh[a]) < $signed({{(SH_W-32){1'b1}}, 32'h8000_0000}))
                w_p[a] = 32'h8000_0000;
            else
                w_p[a] = w_sh[a][31:0];
            // exact non-positive integers step one cell lower
            w_base[a] = CELL_W'($signed(w_p[a]) >>> FRAC_BITS);
            if (($signed(w_p[a]) <= 0) && (w_p[a][FRAC_BITS-1:0] == '0))
                w_base[a] = w_base[a] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r_prod[a]        <= PR_W'($signed(w_pos[a]) * $signed({1'b0, r_freq}));
                r_ctx0.p[a]      <= w_p[a];
                r_ctx0.base[a]   <= w_base[a];
                r_ctx0.best[a]   <= '0;
            end
            r_ctx0.bestd <= '0;
        end
    end

    // ---------------- search chain: z outer, y, x inner ----------------
    t_ctx w_ctx [NCELL+1];
    assign w_ctx[0] = r_ctx0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        localparam int DX = (g % SPAN) - NEIGHBOR_REACH;
        localparam int DY = ((g / SPAN) % SPAN) - NEIGHBOR_REACH;
        localparam int DZ = (g / (SPAN * SPAN)) - NEIGHBOR_REACH;

        cnh_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_first (g == 0),
            .i_dx    (OFF_W'(DX)),
            .i_dy    (OFF_W'(DY)),
            .i_dz    (OFF_W'(DZ)),
            .i_k0    (w_k0),
            .i_k1    (w_k1),
            .i_k2    (w_k2),
            .i_ctx   (w_ctx[g]),
            .o_ctx   (w_ctx[g+1])
        );
    end

    // ---------------- back end: winner hash and distance ----------------
    t_ctx            w_win;
    logic [V_W-1:0]  r_v;
    logic [HC_W-1:0] r_fc [3];
    logic [J_W-1:0]  w_rjit;
    logic [J_W-1:0]  r_jd [JD_N];
    logic [R_W-1:0]  w_root;
    logic [RES_W-1:0] w_res;
    logic [31:0]     w_sat;
    logic [31:0]     r_out;

    assign w_win = w_ctx[NCELL];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v <= V_W'(w_win.bestd) + (V_W'(w_win.bestd) << 1);
            for (int a = 0; a < 3; a++)
                r_fc[a] <= HC_W'($signed(w_win.best[a]) >>> FRAC_BITS);
            r_jd[0] <= w_rjit;
            for (int s = 1; s < JD_N; s++) r_jd[s] <= r_jd[s-1];
        end
    end

    cnh_hash u_rhash (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_fc[0]),
        .i_y   (r_fc[1]),
        .i_z   (r_fc[2]),
        .i_k   (w_kr),
        .o_jit (w_rjit)
    );

    cnh_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r_v),
        .o_root (w_root)
    );

    always_comb begin
        w_res = RES_W'($signed(r_jd[JD_N-1]));
        if (r_dist_en)
            w_res = w_res + RES_W'(w_root) - RES_W'(1 << FRAC_BITS);
        if ($signed(w_res) > $signed(RES_W'(32'h7fff_ffff)))
            w_sat = 32'h7fff_ffff;
        else if ($signed(w_res) < $signed({{(RES_W-32){1'b1}}, 32'h8000_0000}))
            w_sat = 32'h8000_0000;
        else
            w_sat = w_res[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= w_sat;
    end

    assign o_valid       = r_out_vld;
    assign o_noise_value = r_out;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |-> !o_ready)
        else $error("input accepted while output stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction not in first stage");

    a_drain_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_D-1] && w_en) |=> r_out_vld)
        else $error("finished transaction lost at output");
`endif

endmodule

### dv/cellular_noise_3d_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cellular_noise_3d_tb: self-checking bench for the 3D cellular noise block
// Positions go in over a valid/ready channel and noise values come back on a
// second one. An in-bench predictor computes each expected value, and a checker
// compares every returned transaction with the oldest expected value. Register
// settings change between test phases, and the two sides idle at random.
// ----------------------------------------------------------------------------
module cellular_noise_3d_tb import cnh_pkg::*;;

    localparam int  LATENCY   = 899;
    localparam int  WDOG_MAX  = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_noise_value;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cellular_noise_3d u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .o_valid(o_valid), .i_ready(i_ready), .o_noise_value(o_noise_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the register file
    logic [23:0] m_freq;
    logic [31:0] m_cseed;
    logic        m_dist_en;
    logic [31:0] m_rseed;

    logic signed [31:0] noise_q[$];   // expected noise values, oldest first
    int  n_err;
    int  send_idle_pct;               // sender gap chance, percent
    int  recv_stall_pct;              // receiver stall chance, percent
    bit  hold_recv;                   // long receiver hold-off in force

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [31:0] cell_hash(longint x, longint y, longint z,
                                              logic [31:0] s);
        logic [31:0] n;
        n = (HK_X * 32'(x) + HK_Y * 32'(y) + HK_Z * 32'(z) + HK_S * s) & 32'h7fffffff;
        n = (n >> HK_SHR) ^ n;
        return (n * (n * n * HK_MUL + HK_ADD1) + HK_ADD2) & 32'h7fffffff;
    endfunction

    function automatic longint cell_jitter(longint x, longint y, longint z,
                                           logic [31:0] s);
        return (64'sd1 <<< FRAC_BITS) - longint'(cell_hash(x, y, z, s) >> (30 - FRAC_BITS));
    endfunction

    // arithmetic shift is floor division by a power of two
    function automatic longint floor_sh(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [31:0] predict_noise(logic [31:0] px, logic [31:0] py,
                                                         logic [31:0] pz);
        longint      p[3], base[3], best[3], fp[3], e, res;
        longint      cx, cy, cz;
        logic [31:0] pin[3];
        logic [63:0] d2, bestd;
        bit          found;
        pin[0] = px; pin[1] = py; pin[2] = pz;
        found = 0;
        bestd = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = clamp32(floor_sh(longint'(signed'(pin[i])) * longint'({40'd0, m_freq}),
                                    FREQ_FRAC));
            base[i] = floor_sh(p[i], FRAC_BITS);
            // exact non-positive integers land one cell lower
            if (p[i] <= 0 && (p[i] & ((64'sd1 <<< FRAC_BITS) - 1)) == 0)
                base[i] = base[i] - 1;
        end
        for (int dz = -NEIGHBOR_REACH; dz <= NEIGHBOR_REACH; dz++)
            for (int dy = -NEIGHBOR_REACH; dy <= NEIGHBOR_REACH; dy++)
                for (int dx = -NEIGHBOR_REACH; dx <= NEIGHBOR_REACH; dx++) begin
                    cx = base[0] + dx; cy = base[1] + dy; cz = base[2] + dz;
                    fp[0] = (cx <<< FRAC_BITS) + cell_jitter(cx, cy, cz, m_cseed);
                    fp[1] = (cy <<< FRAC_BITS) + cell_jitter(cx, cy, cz, m_cseed + 32'd1);
                    fp[2] = (cz <<< FRAC_BITS) + cell_jitter(cx, cy, cz, m_cseed + 32'd2);
                    d2 = 0;
                    for (int i = 0; i < 3; i++) begin
                        e = fp[i] - p[i];
                        d2 = d2 + 64'(e * e);
                    end
                    // strict compare: first point found wins ties
                    if (!found || d2 < bestd) begin
                        found = 1;
                        bestd = d2;
                        best = fp;
                    end
                end
        res = 0;
        if (m_dist_en)
            res = int_sqrt(64'd3 * bestd) - (64'sd1 <<< FRAC_BITS);
        res = res + cell_jitter(floor_sh(best[0], FRAC_BITS), floor_sh(best[1], FRAC_BITS),
                                floor_sh(best[2], FRAC_BITS), m_rseed);
        return 32'(clamp32(res));
    endfunction

    // ---------------- checker ----------------
    task automatic report_mismatch(string what);
        n_err++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        logic signed [31:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (noise_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction noise=%h", o_noise_value));
            end else begin
                want = noise_q.pop_front();
                if (o_noise_value !== want)
                    report_mismatch($sformatf("noise_value got %h want %h",
                                              o_noise_value, want));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else if (hold_recv)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles with no transaction on either channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WDOG_MAX) begin
                $display("watchdog expired, %0d values outstanding", noise_q.size());
                $display("** cellular_noise_3d: FAILED **");
                $finish;
            end
        end
    end

    // ---------------- driver tasks ----------------
    // valid stays up between back-to-back transactions; callers drop it
    // before they stop sending
    task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= x; i_pos_y <= y; i_pos_z <= z;
        do @(posedge i_clk); while (!o_ready);
        // accepted at this edge; predict with the registers in force now
        noise_q.push_back(predict_noise(x, y, z));
    endtask

    task automatic send_random(int n);
        logic [31:0] v[3];
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(5))
                    0: v[i] = $urandom();
                    1: v[i] = {16'($urandom), 16'd0};            // exact integers
                    2: v[i] = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
                    3: v[i] = {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
                    default: v[i] = 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
                endcase
            end
            send_pos(v[0], v[1], v[2]);
        end
    endtask

    // wait for every outstanding value, then let the pipe fully drain
    task automatic drain();
        i_valid <= 1'b0;
        while (noise_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    // back-to-back writes go straight from access to the next setup phase
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FREQ:    m_freq    = val[23:0];
            REG_CSEED:   m_cseed   = val;
            REG_DIST_EN: m_dist_en = val[0];
            REG_RSEED:   m_rseed   = val;
        endcase
    endtask

    task automatic set_regs(logic [23:0] f, logic [31:0] cs, logic de, logic [31:0] rs);
        drain();
        reg_write(REG_FREQ, {8'd0, f});
        reg_write(REG_CSEED, cs);
        reg_write(REG_DIST_EN, {31'd0, de});
        reg_write(REG_RSEED, rs);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_pos(32'h0, 32'h0, 32'h0);
        send_pos(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
        send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pos(32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_pos(32'hffff_ffff, 32'h0000_0001, 32'hfffe_0000);
        send_pos(32'h0003_4567, 32'hfff1_2345, 32'h0010_0000);
        set_regs(24'hff_ffff, 32'hffff_ffff, 1'b1, 32'h8000_0000);
        send_pos(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_pos(32'h0001_0000, 32'h0002_8000, 32'hfffd_0000);
        send_pos(32'h0, 32'hffff_ffff, 32'h0000_0100);
        set_regs(24'h0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff);
        send_pos(32'h1234_5678, 32'h8765_4321, 32'h0);
        send_pos(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        set_regs(24'h00_0001, 32'h8000_0000, 1'b0, 32'hffff_ffff);
        send_pos(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_pos(32'h0002_0000, 32'hfffe_0000, 32'h0);
    endtask

    task automatic test_random_phases();
        set_regs(24'h01_0000, 32'd0, 1'b1, 32'd0);
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(200);
        set_regs(24'($urandom), $urandom(), 1'b1, $urandom());
        send_idle_pct = 70; recv_stall_pct = 0;  send_random(150);
        set_regs(24'h00_4000, $urandom(), 1'b0, $urandom());
        send_idle_pct = 0;  recv_stall_pct = 70; send_random(200);
        set_regs(24'($urandom_range(1 << 20)), $urandom(), 1'($urandom), $urandom());
        send_idle_pct = 28; recv_stall_pct = 28; send_random(150);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        // receiver holds off; the first batch reaches the output and stalls the
        // chain, so the second batch is offered against a stalled pipe
        fork
            begin
                hold_recv = 1;
                repeat (3 * LATENCY) @(posedge i_clk);
                hold_recv = 0;
            end
            begin
                send_random(60);
                i_valid <= 1'b0;
                repeat (LATENCY) @(posedge i_clk);
                send_random(60);
            end
        join
        // sender pauses until everything is back, then resumes
        i_valid <= 1'b0;
        while (noise_q.size() != 0) @(posedge i_clk);
        send_random(30);
    endtask

    initial begin
        n_err = 0; hold_recv = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        m_freq = 24'h01_0000; m_cseed = 0; m_dist_en = 0; m_rseed = 0;
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 0; pwdata = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        test_backpressure();

        i_valid <= 1'b0;
        while (noise_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("** cellular_noise_3d: PASSED **");
        end else begin
            $display("** cellular_noise_3d: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
src/cnh_pkg.sv
src/cnh_hash.sv
src/cnh_cell.sv
src/cnh_sqrt.sv
src/cellular_noise_3d.sv
dv/cellular_noise_3d_tb.sv
